FILE: rtl/uapq_pkg.sv
// Package for the unsorted-array min-priority queue.
// Holds field widths, reset values, operation codes and the control structs.
// Depends on nothing; every other file of the block imports it.
package uapq_pkg;

	localparam int unsigned DEPTH_DEFAULT = 64;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned CAP_W = 7;
	localparam int unsigned OCC_W = 7;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	typedef struct packed {
		logic accept;
		logic scan;
		logic shift;
		logic publish;
	} uapq_cmd_t;

	typedef struct packed {
		logic deq_go;
		logic op_deq;
		logic last_scan;
		logic best_last;
		logic shift_last;
		logic out_free;
	} uapq_status_t;

endpackage

FILE: rtl/uapq_if.sv
// Handshake interfaces for the request, result and configuration channels.
// Depends on uapq_pkg for the payload widths.

interface uapq_req_if;
	import uapq_pkg::*;
	logic valid;
	logic ready;
	logic op;
	logic signed [VAL_W-1:0] value;
	modport source (output valid, output op, output value, input ready);
	modport sink (input valid, input op, input value, output ready);
endinterface

interface uapq_rsp_if;
	import uapq_pkg::*;
	logic valid;
	logic ready;
	logic ok;
	logic signed [VAL_W-1:0] min_value;
	logic [OCC_W-1:0] occupancy;
	modport source (output valid, output ok, output min_value, output occupancy, input ready);
	modport sink (input valid, input ok, input min_value, input occupancy, output ready);
endinterface

interface uapq_cfg_if;
	import uapq_pkg::*;
	logic valid;
	logic ready;
	logic [CAP_W-1:0] capacity;
	modport source (output valid, output capacity, input ready);
	modport sink (input valid, input capacity, output ready);
endinterface

FILE: rtl/uapq_ctrl.sv
// Controller state machine of the priority queue.
// Sequences accept, scan, shift and result publishing; depends on uapq_pkg.
module uapq_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  uapq_pkg::uapq_status_t st,
	output uapq_pkg::uapq_cmd_t    cmd
);
	import uapq_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_SHIFT = 4'b0100,
		ST_FIN   = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = st.deq_go ? ST_SCAN : ST_FIN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (st.last_scan) begin
					state_d = st.best_last ? ST_FIN : ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				cmd.shift = 1'b1;
				if (st.shift_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (st.out_free) begin
					cmd.publish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_scan_is_deq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_SHIFT) |-> st.op_deq)
		else $error("scan or shift running for an enqueue");

	a_fin_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && !st.out_free) |=> (state_q == ST_FIN))
		else $error("result dropped while the output register was busy");

endmodule

FILE: rtl/uapq_dp.sv
// Datapath of the priority queue: entry memory, count, scan and shift logic,
// capacity register and result register. Depends on uapq_pkg and uapq_if.
module uapq_dp #(
	parameter int unsigned DEPTH = uapq_pkg::DEPTH_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_op,
	input  logic signed [uapq_pkg::VAL_W-1:0] in_value,
	uapq_rsp_if.source                        rsp,
	uapq_cfg_if.sink                          cfg,
	input  uapq_pkg::uapq_cmd_t               cmd,
	output uapq_pkg::uapq_status_t            st
);
	import uapq_pkg::*;

	localparam int unsigned IW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned XW = (CW > CAP_W) ? CW : CAP_W;
	localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

	logic signed [VAL_W-1:0] mem [DEPTH];
	logic signed [VAL_W-1:0] rdata_q;
	logic signed [VAL_W-1:0] best_val_q;
	logic signed [VAL_W-1:0] best_val_nx;
	logic signed [VAL_W-1:0] minv_q;
	logic [IW-1:0]           best_idx_q;
	logic [IW-1:0]           best_idx_nx;
	logic [IW-1:0]           idx_q;
	logic [IW-1:0]           rd_addr;
	logic [IW-1:0]           wr_addr;
	logic signed [VAL_W-1:0] wr_data;
	logic                    wr_en;
	logic [CW-1:0]           count_q;
	logic [XW-1:0]           count_x;
	logic [CAP_W-1:0]        cap_q;
	logic                    room;
	logic                    op_q;
	logic                    ok_q;
	logic                    out_valid_q;
	logic                    out_ok_q;
	logic signed [VAL_W-1:0] out_min_q;
	logic [OCC_W-1:0]        out_occ_q;

	assign count_x = XW'(count_q);
	assign room = (count_x < XW'(cap_q)) && (count_x < DEPTH_X);

	always_comb begin
		if (idx_q == '0 || rdata_q < best_val_q) begin
			best_val_nx = rdata_q;
			best_idx_nx = idx_q;
		end else begin
			best_val_nx = best_val_q;
			best_idx_nx = best_idx_q;
		end
	end

	assign st.deq_go = (in_op == OP_DEQ) && (count_q != '0);
	assign st.op_deq = (op_q == OP_DEQ);
	assign st.last_scan = (CW'(idx_q) + CW'(1) == count_q);
	assign st.best_last = (CW'(best_idx_nx) + CW'(1) == count_q);
	assign st.shift_last = (CW'(idx_q) + CW'(2) == count_q);
	assign st.out_free = !out_valid_q || rsp.ready;

	always_comb begin
		rd_addr = idx_q + IW'(1);
		wr_en = 1'b0;
		wr_addr = idx_q;
		wr_data = rdata_q;
		if (cmd.accept) begin
			rd_addr = '0;
			wr_addr = count_q[IW-1:0];
			wr_data = in_value;
			wr_en = (in_op == OP_ENQ) && room;
		end else if (cmd.scan && st.last_scan) begin
			rd_addr = best_idx_nx + IW'(1);
		end else if (cmd.shift) begin
			rd_addr = idx_q + IW'(2);
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q <= in_op;
			idx_q <= '0;
			minv_q <= '0;
			ok_q <= (in_op == OP_ENQ) ? room : (count_q != '0);
		end else if (cmd.scan) begin
			best_val_q <= best_val_nx;
			best_idx_q <= best_idx_nx;
			if (st.last_scan) begin
				minv_q <= best_val_nx;
				idx_q <= best_idx_nx;
			end else begin
				idx_q <= idx_q + IW'(1);
			end
		end else if (cmd.shift) begin
			idx_q <= idx_q + IW'(1);
		end
		if (cmd.publish) begin
			out_ok_q <= ok_q;
			out_min_q <= minv_q;
			out_occ_q <= count_x[OCC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q <= CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept && in_op == OP_ENQ && room) begin
				count_q <= count_q + CW'(1);
			end else if ((cmd.scan && st.last_scan && st.best_last) ||
					(cmd.shift && st.shift_last)) begin
				count_q <= count_q - CW'(1);
			end
			if (cfg.valid) begin
				cap_q <= cfg.capacity;
			end
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid_q;
	assign rsp.ok = out_ok_q;
	assign rsp.min_value = out_min_q;
	assign rsp.occupancy = out_occ_q;

	a_enq_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && wr_en) |-> (count_x < DEPTH_X))
		else $error("enqueue write past the built depth");

	a_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> ($past(cmd.accept) || $past(cmd.scan) || $past(cmd.shift)))
		else $error("count changed outside an operation");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (ok_q || minv_q == '0))
		else $error("failed operation carries a nonzero value");

endmodule

FILE: rtl/unsorted_array_min_priority_queue.sv
// Unsorted-array min-priority queue of signed 32-bit values held in one memory
// of DEPTH entries in insertion order. An enqueue appends when there is room,
// then hands its result to the output register. A dequeue reads every held
// entry once through the single registered read port to find the smallest
// (the earliest on a tie), then moves each later entry down one place, one
// entry per cycle over the same port. One transaction is worked on at a
// time; a finished result waits in an output register so the next request
// can be taken. Capacity writes take effect at once and are limited to DEPTH
// internally.
// Depends on uapq_pkg, uapq_if, uapq_ctrl and uapq_dp.
module unsorted_array_min_priority_queue #(
	parameter int unsigned DEPTH = uapq_pkg::DEPTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	uapq_req_if.sink   req,
	uapq_rsp_if.source rsp,
	uapq_cfg_if.sink   cfg
);
	import uapq_pkg::*;

	uapq_cmd_t    cmd;
	uapq_status_t st;
	logic         in_ready;

	assign req.ready = in_ready;

	uapq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	uapq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_op    (req.op),
		.in_value (req.value),
		.rsp      (rsp),
		.cfg      (cfg),
		.cmd      (cmd),
		.st       (st)
	);

endmodule
